// ===== src/lswc_pkg.sv =====
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared types and constants for the line segment window clipper.
// ----------------------------------------------------------------------------
package lswc_pkg;

  // Control that travels with every item down the pipeline.
  typedef struct packed {
    logic valid;
    logic reject;
  } lswc_ctrl_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_BOTTOM = 3'd2,
    REG_TOP    = 3'd3
  } lswc_reg_t;

  localparam int NUM_EDGES = 4;

  // Endpoint lanes of the divider chain.
  localparam int LANE_START_X = 0;
  localparam int LANE_START_Y = 1;
  localparam int LANE_END_X   = 2;
  localparam int LANE_END_Y   = 3;
  localparam int NUM_LANES    = 4;

endpackage

// ===== src/lswc_edge_cell.sv =====
// ----------------------------------------------------------------------------
// lswc_edge_cell
// One window edge of the parametric clipper: narrows [u1,u2] or rejects.
// ----------------------------------------------------------------------------
module lswc_edge_cell import lswc_pkg::*; #(
  parameter int W    = 16,
  parameter int EDGE = 0,
  parameter int DW   = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  lswc_ctrl_t                      ctrl_i,
  input  logic [NUM_EDGES-1:0][W:0]       p_i,
  input  logic [NUM_EDGES-1:0][W:0]       q_i,
  input  logic [W-1:0]                    u1n_i,
  input  logic [W-1:0]                    u1d_i,
  input  logic [W-1:0]                    u2n_i,
  input  logic [W-1:0]                    u2d_i,
  input  logic [DW-1:0]                   data_i,
  output lswc_ctrl_t                      ctrl_o,
  output logic [NUM_EDGES-1:0][W:0]       p_o,
  output logic [NUM_EDGES-1:0][W:0]       q_o,
  output logic [W-1:0]                    u1n_o,
  output logic [W-1:0]                    u1d_o,
  output logic [W-1:0]                    u2n_o,
  output logic [W-1:0]                    u2d_o,
  output logic [DW-1:0]                   data_o
);

  logic signed [W:0] p_s, q_s;
  logic [W:0]        p_abs, q_abs;
  logic              rneg_c;

  assign p_s    = $signed(p_i[EDGE]);
  assign q_s    = $signed(q_i[EDGE]);
  assign p_abs  = p_s[W] ? -p_s : p_s;
  assign q_abs  = q_s[W] ? -q_s : q_s;
  // The candidate fraction is q/p; it is negative when the signs differ and q is nonzero.
  assign rneg_c = p_s[W] ? (!q_s[W] && (q_s != '0)) : q_s[W];

  lswc_ctrl_t                  a_ctrl_r;
  logic [NUM_EDGES-1:0][W:0]   a_p_r, a_q_r;
  logic [DW-1:0]               a_data_r;
  logic [W-1:0]                a_u1n_r, a_u1d_r, a_u2n_r, a_u2d_r;
  logic                        a_pz_r, a_pneg_r, a_qneg_r, a_rneg_r;
  logic [W-1:0]                a_rmag_r, a_rden_r;
  logic [2*W-1:0]              a_pr1_r, a_pu1_r, a_pr2_r, a_pu2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctrl_r <= '0;
    end else if (en) begin
      a_ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r    <= p_i;
      a_q_r    <= q_i;
      a_data_r <= data_i;
      a_u1n_r  <= u1n_i;
      a_u1d_r  <= u1d_i;
      a_u2n_r  <= u2n_i;
      a_u2d_r  <= u2d_i;
      a_pz_r   <= (p_s == '0);
      a_pneg_r <= p_s[W];
      a_qneg_r <= q_s[W];
      a_rneg_r <= rneg_c;
      a_rmag_r <= q_abs[W-1:0];
      a_rden_r <= p_abs[W-1:0];
      a_pr1_r  <= q_abs[W-1:0] * u1d_i;
      a_pu1_r  <= u1n_i * p_abs[W-1:0];
      a_pr2_r  <= q_abs[W-1:0] * u2d_i;
      a_pu2_r  <= u2n_i * p_abs[W-1:0];
    end
  end

  // Both bounds are non-negative, so a negative candidate is below either.
  logic       gt1, lt1, gt2, lt2;
  logic       rej_c;
  logic [W-1:0] u1n_c, u1d_c, u2n_c, u2d_c;

  assign gt1 = !a_rneg_r && (a_pr1_r > a_pu1_r);
  assign lt1 = a_rneg_r || (a_pr1_r < a_pu1_r);
  assign gt2 = !a_rneg_r && (a_pr2_r > a_pu2_r);
  assign lt2 = a_rneg_r || (a_pr2_r < a_pu2_r);

  always_comb begin
    rej_c = a_ctrl_r.reject;
    u1n_c = a_u1n_r;
    u1d_c = a_u1d_r;
    u2n_c = a_u2n_r;
    u2d_c = a_u2d_r;
    if (!rej_c) begin
      if (a_pz_r) begin
        rej_c = a_qneg_r;
      end else if (a_pneg_r) begin
        if (gt2) begin
          rej_c = 1'b1;
        end else if (gt1) begin
          u1n_c = a_rmag_r;
          u1d_c = a_rden_r;
        end
      end else begin
        if (lt1) begin
          rej_c = 1'b1;
        end else if (lt2) begin
          u2n_c = a_rmag_r;
          u2d_c = a_rden_r;
        end
      end
    end
  end

  lswc_ctrl_t                  b_ctrl_r;
  logic [NUM_EDGES-1:0][W:0]   b_p_r, b_q_r;
  logic [DW-1:0]               b_data_r;
  logic [W-1:0]                b_u1n_r, b_u1d_r, b_u2n_r, b_u2d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctrl_r <= '0;
    end else if (en) begin
      b_ctrl_r.valid  <= a_ctrl_r.valid;
      b_ctrl_r.reject <= rej_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_p_r    <= a_p_r;
      b_q_r    <= a_q_r;
      b_data_r <= a_data_r;
      b_u1n_r  <= u1n_c;
      b_u1d_r  <= u1d_c;
      b_u2n_r  <= u2n_c;
      b_u2d_r  <= u2d_c;
    end
  end

  assign ctrl_o = b_ctrl_r;
  assign p_o    = b_p_r;
  assign q_o    = b_q_r;
  assign data_o = b_data_r;
  assign u1n_o  = b_u1n_r;
  assign u1d_o  = b_u1d_r;
  assign u2n_o  = b_u2n_r;
  assign u2d_o  = b_u2d_r;

endmodule

// ===== src/lswc_div_cell.sv =====
// ----------------------------------------------------------------------------
// lswc_div_cell
// One restoring division step for the four endpoint lanes.
// ----------------------------------------------------------------------------
module lswc_div_cell import lswc_pkg::*; #(
  parameter int W  = 16,
  parameter int DW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  lswc_ctrl_t                    ctrl_i,
  input  logic [NUM_LANES-1:0][W:0]     rem_i,
  input  logic [NUM_LANES-1:0][W-1:0]   low_i,
  input  logic [NUM_LANES-1:0][W-1:0]   quo_i,
  input  logic [NUM_LANES-1:0][W:0]     den_i,
  input  logic [DW-1:0]                 data_i,
  output lswc_ctrl_t                    ctrl_o,
  output logic [NUM_LANES-1:0][W:0]     rem_o,
  output logic [NUM_LANES-1:0][W-1:0]   low_o,
  output logic [NUM_LANES-1:0][W-1:0]   quo_o,
  output logic [NUM_LANES-1:0][W:0]     den_o,
  output logic [DW-1:0]                 data_o
);

  logic [NUM_LANES-1:0][W:0]   rem_c;
  logic [NUM_LANES-1:0][W-1:0] low_c, quo_c;

  always_comb begin
    logic [W+1:0] t;
    logic [W+1:0] diff;
    for (int j = 0; j < NUM_LANES; j++) begin
      t    = {rem_i[j], low_i[j][W-1]};
      diff = t - {1'b0, den_i[j]};
      // The remainder stays below the divisor, so it fits in W+1 bits.
      if (t >= {1'b0, den_i[j]}) begin
        rem_c[j] = diff[W:0];
        quo_c[j] = {quo_i[j][W-2:0], 1'b1};
      end else begin
        rem_c[j] = t[W:0];
        quo_c[j] = {quo_i[j][W-2:0], 1'b0};
      end
      low_c[j] = {low_i[j][W-2:0], 1'b0};
    end
  end

  lswc_ctrl_t                  ctrl_r;
  logic [NUM_LANES-1:0][W:0]   rem_r, den_r;
  logic [NUM_LANES-1:0][W-1:0] low_r, quo_r;
  logic [DW-1:0]               data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_c;
      low_r  <= low_c;
      quo_r  <= quo_c;
      den_r  <= den_i;
      data_r <= data_i;
    end
  end

  assign ctrl_o = ctrl_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;
  assign data_o = data_r;

endmodule

// ===== src/line_segment_window_clipper_core.sv =====
// ----------------------------------------------------------------------------
// line_segment_window_clipper_core
// Parametric (entry/exit) clipping of line segments against a window.
// ----------------------------------------------------------------------------
// Segments enter on the in_ channel and one result per segment leaves on the
// out_ channel; a transaction completes when valid is high and stall is low.
// The window is written on the cfg_ channel (index 0 left, 1 right, 2 bottom,
// 3 top; higher indexes are ignored), which is always ready. Write it only
// while no segment is in flight.
// A segment accepted on the in_ channel passes through the entry stage, the
// A and B stages of each edge cell, stages F1 and F2 for the final bound check
// and divider setup, one divider cell per quotient bit, and the output register.
// One segment is accepted every cycle while the output is drained.
// A skid register behind the output register absorbs the item that arrives
// while the receiver stalls; once it is full, in_stall rises and the whole
// pipeline holds until the output moves again.
// Reset clears the window to zero and empties the pipeline and output.
// Rejected segments come out with out_visible low and all coordinates zero.
// ----------------------------------------------------------------------------
module line_segment_window_clipper_core import lswc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_visible,
  output logic signed [COORD_BITS-1:0] out_clipped_start_x,
  output logic signed [COORD_BITS-1:0] out_clipped_start_y,
  output logic signed [COORD_BITS-1:0] out_clipped_end_x,
  output logic signed [COORD_BITS-1:0] out_clipped_end_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int W   = COORD_BITS;
  localparam int EDW = 4*W + 2;
  localparam int DDW = 2*W + 2;

  // Window registers.
  logic [W-1:0] win_left_r, win_right_r, win_bottom_r, win_top_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_right_r  <= '0;
      win_bottom_r <= '0;
      win_top_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (lswc_reg_t'(cfg_index))
        REG_LEFT:   win_left_r   <= cfg_data;
        REG_RIGHT:  win_right_r  <= cfg_data;
        REG_BOTTOM: win_bottom_r <= cfg_data;
        REG_TOP:    win_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic skid_full_r;
  logic en;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  // Entry stage: deltas and the p/q terms of every window edge.
  logic [W:0] x1_e, y1_e, x2_e, y2_e, dx_c, dy_c, adx_c, ady_c;
  logic [NUM_EDGES-1:0][W:0] p_c, q_c;

  assign x1_e  = {in_start_x[W-1], in_start_x};
  assign y1_e  = {in_start_y[W-1], in_start_y};
  assign x2_e  = {in_end_x[W-1], in_end_x};
  assign y2_e  = {in_end_y[W-1], in_end_y};
  assign dx_c  = x2_e - x1_e;
  assign dy_c  = y2_e - y1_e;
  assign adx_c = dx_c[W] ? -dx_c : dx_c;
  assign ady_c = dy_c[W] ? -dy_c : dy_c;

  assign p_c[0] = -dx_c;
  assign q_c[0] = x1_e - {win_left_r[W-1], win_left_r};
  assign p_c[1] = dx_c;
  assign q_c[1] = {win_right_r[W-1], win_right_r} - x1_e;
  assign p_c[2] = -dy_c;
  assign q_c[2] = y1_e - {win_bottom_r[W-1], win_bottom_r};
  assign p_c[3] = dy_c;
  assign q_c[3] = {win_top_r[W-1], win_top_r} - y1_e;

  lswc_ctrl_t                e_ctrl_r;
  logic [NUM_EDGES-1:0][W:0] e_p_r, e_q_r;
  logic [EDW-1:0]            e_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_ctrl_r <= '0;
    end else if (en) begin
      e_ctrl_r.valid  <= in_valid;
      e_ctrl_r.reject <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_p_r    <= p_c;
      e_q_r    <= q_c;
      e_data_r <= {in_start_x, in_start_y, adx_c[W-1:0], ady_c[W-1:0],
                   dx_c[W], dy_c[W]};
    end
  end

  // Chain of edge cells.
  lswc_ctrl_t                ec_ctrl [0:NUM_EDGES];
  logic [NUM_EDGES-1:0][W:0] ec_p    [0:NUM_EDGES];
  logic [NUM_EDGES-1:0][W:0] ec_q    [0:NUM_EDGES];
  logic [W-1:0]              ec_u1n  [0:NUM_EDGES];
  logic [W-1:0]              ec_u1d  [0:NUM_EDGES];
  logic [W-1:0]              ec_u2n  [0:NUM_EDGES];
  logic [W-1:0]              ec_u2d  [0:NUM_EDGES];
  logic [EDW-1:0]            ec_data [0:NUM_EDGES];

  assign ec_ctrl[0] = e_ctrl_r;
  assign ec_p[0]    = e_p_r;
  assign ec_q[0]    = e_q_r;
  assign ec_data[0] = e_data_r;
  assign ec_u1n[0]  = '0;
  assign ec_u1d[0]  = W'(1);
  assign ec_u2n[0]  = W'(1);
  assign ec_u2d[0]  = W'(1);

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
    lswc_edge_cell #(.W(W), .EDGE(k), .DW(EDW)) u_edge (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctrl_i (ec_ctrl[k]),
      .p_i    (ec_p[k]),
      .q_i    (ec_q[k]),
      .u1n_i  (ec_u1n[k]),
      .u1d_i  (ec_u1d[k]),
      .u2n_i  (ec_u2n[k]),
      .u2d_i  (ec_u2d[k]),
      .data_i (ec_data[k]),
      .ctrl_o (ec_ctrl[k+1]),
      .p_o    (ec_p[k+1]),
      .q_o    (ec_q[k+1]),
      .u1n_o  (ec_u1n[k+1]),
      .u1d_o  (ec_u1d[k+1]),
      .u2n_o  (ec_u2n[k+1]),
      .u2d_o  (ec_u2d[k+1]),
      .data_o (ec_data[k+1])
    );
  end

  // Stage F1: products for the final u1 < u2 check and delta * numerator.
  logic [W-1:0] ed_x1, ed_y1, ed_adx, ed_ady;
  logic         ed_sdx, ed_sdy;

  assign ed_x1  = ec_data[NUM_EDGES][4*W+1:3*W+2];
  assign ed_y1  = ec_data[NUM_EDGES][3*W+1:2*W+2];
  assign ed_adx = ec_data[NUM_EDGES][2*W+1:W+2];
  assign ed_ady = ec_data[NUM_EDGES][W+1:2];
  assign ed_sdx = ec_data[NUM_EDGES][1];
  assign ed_sdy = ec_data[NUM_EDGES][0];

  lswc_ctrl_t                     f1_ctrl_r;
  logic [2*W-1:0]                 f1_p12_r, f1_p21_r;
  logic [NUM_LANES-1:0][2*W-1:0]  f1_m_r;
  logic [W-1:0]                   f1_d1_r, f1_d2_r;
  logic [DDW-1:0]                 f1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_ctrl_r <= '0;
    end else if (en) begin
      f1_ctrl_r <= ec_ctrl[NUM_EDGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_p12_r               <= ec_u1n[NUM_EDGES] * ec_u2d[NUM_EDGES];
      f1_p21_r               <= ec_u2n[NUM_EDGES] * ec_u1d[NUM_EDGES];
      f1_m_r[LANE_START_X]   <= ed_adx * ec_u1n[NUM_EDGES];
      f1_m_r[LANE_START_Y]   <= ed_ady * ec_u1n[NUM_EDGES];
      f1_m_r[LANE_END_X]     <= ed_adx * ec_u2n[NUM_EDGES];
      f1_m_r[LANE_END_Y]     <= ed_ady * ec_u2n[NUM_EDGES];
      f1_d1_r                <= ec_u1d[NUM_EDGES];
      f1_d2_r                <= ec_u2d[NUM_EDGES];
      f1_data_r              <= {ed_x1, ed_y1, ed_sdx, ed_sdy};
    end
  end

  // Stage F2: rounding offset and divider setup. A positive delta rounds
  // with (2m + d) / 2d, a negative one with (2m + d - 1) / 2d.
  logic [NUM_LANES-1:0][2*W:0] n_c;
  logic [NUM_LANES-1:0][W:0]   den_c;
  logic [NUM_LANES-1:0][W:0]   rem0_c;
  logic [NUM_LANES-1:0][W-1:0] low0_c;
  logic                        f1_sdx, f1_sdy;

  assign f1_sdx = f1_data_r[1];
  assign f1_sdy = f1_data_r[0];

  always_comb begin
    logic [W-1:0] d;
    logic         neg;
    for (int j = 0; j < NUM_LANES; j++) begin
      d         = (j == LANE_START_X || j == LANE_START_Y) ? f1_d1_r : f1_d2_r;
      neg       = (j == LANE_START_X || j == LANE_END_X) ? f1_sdx : f1_sdy;
      n_c[j]    = {f1_m_r[j], 1'b0} + (2*W+1)'(d) - (2*W+1)'(neg);
      den_c[j]  = {d, 1'b0};
      rem0_c[j] = n_c[j][2*W:W];
      low0_c[j] = n_c[j][W-1:0];
    end
  end

  lswc_ctrl_t                  f2_ctrl_r;
  logic [NUM_LANES-1:0][W:0]   f2_rem_r, f2_den_r;
  logic [NUM_LANES-1:0][W-1:0] f2_low_r;
  logic [DDW-1:0]              f2_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_ctrl_r <= '0;
    end else if (en) begin
      f2_ctrl_r.valid  <= f1_ctrl_r.valid;
      f2_ctrl_r.reject <= f1_ctrl_r.reject || (f1_p12_r >= f1_p21_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_rem_r  <= rem0_c;
      f2_den_r  <= den_c;
      f2_low_r  <= low0_c;
      f2_data_r <= f1_data_r;
    end
  end

  // Divider chain, one quotient bit per cell.
  lswc_ctrl_t                  dv_ctrl [0:W];
  logic [NUM_LANES-1:0][W:0]   dv_rem  [0:W];
  logic [NUM_LANES-1:0][W-1:0] dv_low  [0:W];
  logic [NUM_LANES-1:0][W-1:0] dv_quo  [0:W];
  logic [NUM_LANES-1:0][W:0]   dv_den  [0:W];
  logic [DDW-1:0]              dv_data [0:W];

  assign dv_ctrl[0] = f2_ctrl_r;
  assign dv_rem[0]  = f2_rem_r;
  assign dv_low[0]  = f2_low_r;
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = f2_den_r;
  assign dv_data[0] = f2_data_r;

  for (genvar s = 0; s < W; s++) begin : g_div
    lswc_div_cell #(.W(W), .DW(DDW)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctrl_i (dv_ctrl[s]),
      .rem_i  (dv_rem[s]),
      .low_i  (dv_low[s]),
      .quo_i  (dv_quo[s]),
      .den_i  (dv_den[s]),
      .data_i (dv_data[s]),
      .ctrl_o (dv_ctrl[s+1]),
      .rem_o  (dv_rem[s+1]),
      .low_o  (dv_low[s+1]),
      .quo_o  (dv_quo[s+1]),
      .den_o  (dv_den[s+1]),
      .data_o (dv_data[s+1])
    );
  end

  // Result assembly: start plus or minus the rounded quotient.
  logic [W-1:0]                res_x1, res_y1;
  logic                        res_sdx, res_sdy;
  logic                        res_visible;
  logic [NUM_LANES-1:0][W-1:0] res_coord;
  logic                        last_valid;

  assign res_x1      = dv_data[W][2*W+1:W+2];
  assign res_y1      = dv_data[W][W+1:2];
  assign res_sdx     = dv_data[W][1];
  assign res_sdy     = dv_data[W][0];
  assign res_visible = !dv_ctrl[W].reject;
  assign last_valid  = dv_ctrl[W].valid;

  always_comb begin
    logic [W-1:0] base;
    logic         neg;
    for (int j = 0; j < NUM_LANES; j++) begin
      base = (j == LANE_START_X || j == LANE_END_X) ? res_x1 : res_y1;
      neg  = (j == LANE_START_X || j == LANE_END_X) ? res_sdx : res_sdy;
      if (!res_visible) begin
        res_coord[j] = '0;
      end else if (neg) begin
        res_coord[j] = base - dv_quo[W][j];
      end else begin
        res_coord[j] = base + dv_quo[W][j];
      end
    end
  end

  // Output register and skid register.
  logic                        out_valid_r;
  logic                        out_visible_r;
  logic [NUM_LANES-1:0][W-1:0] out_coord_r;
  logic                        skid_visible_r;
  logic [NUM_LANES-1:0][W-1:0] skid_coord_r;
  logic                        out_hold;

  assign out_hold = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_hold) begin
      if (last_valid && !skid_full_r) begin
        skid_full_r <= 1'b1;
      end
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_hold) begin
      if (!skid_full_r) begin
        skid_visible_r <= res_visible;
        skid_coord_r   <= res_coord;
      end
    end else if (skid_full_r) begin
      out_visible_r <= skid_visible_r;
      out_coord_r   <= skid_coord_r;
    end else begin
      out_visible_r <= res_visible;
      out_coord_r   <= res_coord;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_visible         = out_visible_r;
  assign out_clipped_start_x = out_coord_r[LANE_START_X];
  assign out_clipped_start_y = out_coord_r[LANE_START_Y];
  assign out_clipped_end_x   = out_coord_r[LANE_END_X];
  assign out_clipped_end_y   = out_coord_r[LANE_END_Y];

  // The skid register only fills behind a result that is waiting.
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid register full while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |=> $stable(dv_ctrl[W].valid))
    else $error("pipeline moved while the skid register was full");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_visible_r) |->
      (out_coord_r[LANE_START_X] == '0 && out_coord_r[LANE_START_Y] == '0 &&
       out_coord_r[LANE_END_X] == '0 && out_coord_r[LANE_END_Y] == '0))
    else $error("rejected segment carries nonzero coordinates");

endmodule
